FILE: rtl/vpv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpv_pkg
// Shared widths, register indexes and the long-division step used by the
// vertex projection pipeline.
// ----------------------------------------------------------------------------
package vpv_pkg;

	localparam int CLIP_W   = 52;
	localparam int MAG_W    = 51;
	localparam int NDC_QB   = 45;
	localparam int DEPTH_QB = 32;

	localparam logic [2:0] REG_COL0   = 3'd0;
	localparam logic [2:0] REG_COL1   = 3'd1;
	localparam logic [2:0] REG_COL2   = 3'd2;
	localparam logic [2:0] REG_COL3   = 3'd3;
	localparam logic [2:0] REG_LEFT   = 3'd4;
	localparam logic [2:0] REG_TOP    = 3'd5;
	localparam logic [2:0] REG_WIDTH  = 3'd6;
	localparam logic [2:0] REG_HEIGHT = 3'd7;

	typedef struct packed {
		logic [MAG_W-1:0]  r;
		logic [NDC_QB-1:0] q;
		logic [NDC_QB-1:0] n;
	} div_lane_t;

	typedef struct packed {
		div_lane_t        lx;
		div_lane_t        ly;
		div_lane_t        lz;
		logic [MAG_W-1:0] ad;
		logic             neg_x;
		logic             neg_y;
		logic             neg_z;
		logic             sat_x;
		logic             sat_y;
		logic             sat_z;
		logic             degen;
	} div_stage_t;

	function automatic div_lane_t div_step(div_lane_t l, logic [MAG_W-1:0] ad);
		logic [MAG_W:0] t;
		div_lane_t      o;
		t   = {l.r, l.n[NDC_QB-1]};
		o.n = {l.n[NDC_QB-2:0], 1'b0};
		if (t >= {1'b0, ad}) begin
			o.r = MAG_W'(t - {1'b0, ad});
			o.q = {l.q[NDC_QB-2:0], 1'b1};
		end else begin
			o.r = t[MAG_W-1:0];
			o.q = {l.q[NDC_QB-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

FILE: rtl/vertex_project_to_viewport_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_project_to_viewport_unit
// Throughput: one vertex per cycle; busy stays low, the 45-stage restoring
// divider sets the depth. Results are strobed for one cycle, no stall.
// Reset clears the pipeline valid bits and loads identity and 640x480.
// ----------------------------------------------------------------------------
module vertex_project_to_viewport_unit
	import vpv_pkg::*;
#(
	parameter int COORD_FRAC_BITS  = 16,
	parameter int MATRIX_FRAC_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output logic               done,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic signed [31:0] depth,
	output logic               degenerate
);

	localparam int C      = COORD_FRAC_BITS;
	localparam int NF_W   = MAG_W + C;
	localparam int MUL_AW = C + 27;
	localparam int PW     = MUL_AW + 17;
	localparam int SW     = PW + 1;
	localparam logic signed [63:0] ONE64   = 64'sd1 <<< C;
	localparam logic signed [63:0] LIM64   = 64'sd1 <<< (C + 25);
	localparam logic signed [63:0] SENT64  = -64'sd9999 * ONE64;
	localparam logic signed [63:0] I32MAX  = 64'sd2147483647;
	localparam logic signed [63:0] I32MIN  = -64'sd2147483648;
	localparam logic signed [31:0] SENT_XY = (SENT64 < I32MIN) ? 32'sh80000000 : 32'(SENT64);
	localparam logic signed [31:0] SENT_Z  = (ONE64 > I32MAX) ? 32'sh7fffffff : 32'(ONE64);

	logic [63:0]        col_q [4];
	logic signed [15:0] left_q, top_q;
	logic [15:0]        width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q[0] <= 64'd4096;
			col_q[1] <= 64'd268435456;
			col_q[2] <= 64'd17592186044416;
			col_q[3] <= 64'd1152921504606846976;
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= 16'd640;
			height_q <= 16'd480;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COL0:   col_q[0] <= cfg_data;
				REG_COL1:   col_q[1] <= cfg_data;
				REG_COL2:   col_q[2] <= cfg_data;
				REG_COL3:   col_q[3] <= cfg_data;
				REG_LEFT:   left_q   <= cfg_data[15:0];
				REG_TOP:    top_q    <= cfg_data[15:0];
				REG_WIDTH:  width_q  <= cfg_data[15:0];
				REG_HEIGHT: height_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic [NDC_QB-1:0]  vdiv_q;
	logic [10:1]        v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			vdiv_q <= '0;
		end else begin
			v_q[1]    <= start;
			v_q[5:2]  <= v_q[4:1];
			vdiv_q    <= {vdiv_q[NDC_QB-2:0], v_q[5]};
			v_q[6]    <= vdiv_q[NDC_QB-1];
			v_q[10:7] <= v_q[9:6];
		end
	end

	// stage 1: input word
	logic signed [31:0] p_s1 [3];
	always_ff @(posedge clk) begin
		p_s1[0] <= pos_x;
		p_s1[1] <= pos_y;
		p_s1[2] <= pos_z;
	end

	// stage 2: products
	logic signed [47:0]       prod_s2 [4][3];
	logic signed [CLIP_W-1:0] bias_s2 [4];
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 3; r++)
				prod_s2[c][r] <= p_s1[r] * $signed(col_q[c][16*r +: 16]);
			bias_s2[c] <= CLIP_W'($signed(col_q[c][63:48])) <<< C;
		end
	end

	// stage 3: clip coordinates
	logic signed [CLIP_W-1:0] clip_s3 [4];
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++)
			clip_s3[c] <= CLIP_W'(prod_s2[c][0]) + CLIP_W'(prod_s2[c][1])
				+ CLIP_W'(prod_s2[c][2]) + bias_s2[c];
	end

	// stage 4: sign and magnitude
	logic [MAG_W-1:0] mag_s4 [4];
	logic             sgn_s4 [4];
	logic             degen_s4;
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			sgn_s4[c] <= clip_s3[c][CLIP_W-1];
			mag_s4[c] <= clip_s3[c][CLIP_W-1] ? MAG_W'(-clip_s3[c])
				: clip_s3[c][MAG_W-1:0];
		end
		degen_s4 <= ((clip_s3[3][CLIP_W-1] ? MAG_W'(-clip_s3[3])
			: clip_s3[3][MAG_W-1:0]) >> MATRIX_FRAC_BITS) == '0;
	end

	// stage 5: divider setup
	logic [NF_W-1:0] nf_x, nf_y, nf_z;
	div_stage_t      div_in_s5;
	assign nf_x = {mag_s4[0], {C{1'b0}}};
	assign nf_y = {mag_s4[1], {C{1'b0}}};
	assign nf_z = {mag_s4[2], {C{1'b0}}};

	always_ff @(posedge clk) begin
		div_in_s5.lx.r  <= mag_s4[0] >> (NDC_QB - C);
		div_in_s5.lx.q  <= '0;
		div_in_s5.lx.n  <= nf_x[NDC_QB-1:0];
		div_in_s5.ly.r  <= mag_s4[1] >> (NDC_QB - C);
		div_in_s5.ly.q  <= '0;
		div_in_s5.ly.n  <= nf_y[NDC_QB-1:0];
		div_in_s5.lz.r  <= mag_s4[2] >> (DEPTH_QB - C);
		div_in_s5.lz.q  <= '0;
		div_in_s5.lz.n  <= {nf_z[DEPTH_QB-1:0], {(NDC_QB-DEPTH_QB){1'b0}}};
		div_in_s5.ad    <= mag_s4[3];
		div_in_s5.neg_x <= sgn_s4[0] != sgn_s4[3];
		div_in_s5.neg_y <= sgn_s4[1] != sgn_s4[3];
		div_in_s5.neg_z <= sgn_s4[2] != sgn_s4[3];
		div_in_s5.sat_x <= (mag_s4[0] >> (NDC_QB - C)) >= mag_s4[3];
		div_in_s5.sat_y <= (mag_s4[1] >> (NDC_QB - C)) >= mag_s4[3];
		div_in_s5.sat_z <= (mag_s4[2] >> (DEPTH_QB - C)) >= mag_s4[3];
		div_in_s5.degen <= degen_s4;
	end

	// divider: one quotient bit per stage
	div_stage_t div_s [NDC_QB];
	for (genvar k = 0; k < NDC_QB; k++) begin : g_div
		div_stage_t cur, nxt;
		if (k == 0) begin : g_first
			assign cur = div_in_s5;
		end else begin : g_next
			assign cur = div_s[k-1];
		end
		always_comb begin
			nxt    = cur;
			nxt.lx = div_step(cur.lx, cur.ad);
			nxt.ly = div_step(cur.ly, cur.ad);
			if (k >= NDC_QB - DEPTH_QB)
				nxt.lz = div_step(cur.lz, cur.ad);
		end
		always_ff @(posedge clk) begin
			div_s[k] <= nxt;
		end
	end

	div_stage_t dq;
	assign dq = div_s[NDC_QB-1];

	// stage 6: clamp and sign quotients
	localparam logic [NDC_QB-1:0]   NDC_LIM   = NDC_QB'(1) << (NDC_QB - 1);
	localparam logic [DEPTH_QB-1:0] DEPTH_LIM = DEPTH_QB'(1) << (DEPTH_QB - 1);
	logic [NDC_QB-1:0]   qx, qy;
	logic [DEPTH_QB-1:0] qz;
	logic signed [NDC_QB:0]   nx_s6, ny_s6;
	logic signed [DEPTH_QB:0] dz_s6;
	logic                     degen_s6;
	assign qx = (dq.sat_x || dq.lx.q > NDC_LIM) ? NDC_LIM : dq.lx.q;
	assign qy = (dq.sat_y || dq.ly.q > NDC_LIM) ? NDC_LIM : dq.ly.q;
	assign qz = (dq.sat_z || dq.lz.q[DEPTH_QB-1:0] > DEPTH_LIM) ? DEPTH_LIM
		: dq.lz.q[DEPTH_QB-1:0];
	always_ff @(posedge clk) begin
		nx_s6    <= dq.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
		ny_s6    <= dq.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
		dz_s6    <= dq.neg_z ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
		degen_s6 <= dq.degen;
	end

	// stage 7: offset and clamp multiplicands
	logic signed [63:0]       ax, ay;
	logic signed [MUL_AW-1:0] ax_s7, ay_s7;
	logic signed [31:0]       dz_s7;
	logic                     degen_s7;
	assign ax = 64'(nx_s6) + ONE64;
	assign ay = ONE64 - 64'(ny_s6);
	always_ff @(posedge clk) begin
		ax_s7    <= (ax > LIM64) ? MUL_AW'(LIM64) : (ax < -LIM64) ? MUL_AW'(-LIM64)
			: MUL_AW'(ax);
		ay_s7    <= (ay > LIM64) ? MUL_AW'(LIM64) : (ay < -LIM64) ? MUL_AW'(-LIM64)
			: MUL_AW'(ay);
		dz_s7    <= (64'(dz_s6) > I32MAX) ? 32'sh7fffffff : 32'(dz_s6);
		degen_s7 <= degen_s6;
	end

	// stage 8: scale by viewport size
	logic signed [PW-1:0] mx_s8, my_s8;
	logic signed [31:0]   dz_s8;
	logic                 degen_s8;
	always_ff @(posedge clk) begin
		mx_s8    <= ax_s7 * $signed({1'b0, width_q});
		my_s8    <= ay_s7 * $signed({1'b0, height_q});
		dz_s8    <= dz_s7;
		degen_s8 <= degen_s7;
	end

	// stage 9: halve toward zero and add origin
	logic signed [SW-1:0] sx_s9, sy_s9;
	logic signed [31:0]   dz_s9;
	logic                 degen_s9;
	always_ff @(posedge clk) begin
		sx_s9 <= ((SW'(mx_s8) + $signed({{(SW-1){1'b0}}, mx_s8[PW-1]})) >>> 1)
			+ (SW'(left_q) <<< C);
		sy_s9 <= ((SW'(my_s8) + $signed({{(SW-1){1'b0}}, my_s8[PW-1]})) >>> 1)
			+ (SW'(top_q) <<< C);
		dz_s9    <= dz_s8;
		degen_s9 <= degen_s8;
	end

	// stage 10: saturate and select sentinel
	always_ff @(posedge clk) begin
		if (degen_s9) begin
			screen_x <= SENT_XY;
			screen_y <= SENT_XY;
			depth    <= SENT_Z;
		end else begin
			screen_x <= (sx_s9 > SW'(I32MAX)) ? 32'sh7fffffff
				: (sx_s9 < SW'(I32MIN)) ? 32'sh80000000 : 32'(sx_s9);
			screen_y <= (sy_s9 > SW'(I32MAX)) ? 32'sh7fffffff
				: (sy_s9 < SW'(I32MIN)) ? 32'sh80000000 : 32'(sy_s9);
			depth    <= dz_s9;
		end
		degenerate <= degen_s9;
	end

	assign done = v_q[10];

endmodule
